// File: rtl/core/kdk_pkg.sv
// Shared constants, types and helpers of the kd-tree nearest-neighbor search block.
package kdk_pkg;

  localparam int COORD_BITS      = 24;
  localparam int DIST_W          = 50;
  localparam int NODE_W          = 13;
  localparam int K_W             = 7;
  localparam int AXIS_W          = 2;
  localparam int DATA_W          = 32;
  localparam int ADDR_W          = 3;

  localparam int TREE_NODES_DEF  = 4096;
  localparam int MAX_K_DEF       = 64;
  localparam int STACK_DEPTH_DEF = 13;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;

  localparam logic REG_NODE_COUNT = 1'b0;

  typedef struct packed {
    logic              clear;
    logic              take;
    logic              dump;
    logic [DIST_W-1:0] sq_dist;
    logic [NODE_W-1:0] node;
    logic [DIST_W-1:0] max_dist2;
    logic [K_W-1:0]    k;
  } heap_cmd_t;

  typedef struct packed {
    logic              busy;
    logic [DIST_W-1:0] bound;
  } heap_sts_t;

  function automatic logic [COORD_BITS:0] abs_diff(logic signed [COORD_BITS-1:0] a,
                                                   logic signed [COORD_BITS-1:0] b);
    logic [COORD_BITS:0] d;
    d = {a[COORD_BITS-1], a} - {b[COORD_BITS-1], b};
    return d[COORD_BITS] ? (~d + 1'b1) : d;
  endfunction

endpackage

// File: rtl/core/kdk_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module kdk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic                                    re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/kdk_heap.sv
// Result heap: collects found nodes, builds and maintains the max-heap, streams results.
module kdk_heap import kdk_pkg::*; #(
  parameter int MAX_K = MAX_K_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  heap_cmd_t         cmd,
  output heap_sts_t         sts,
  output logic              out_strobe,
  output logic              out_entry_valid,
  output logic [NODE_W-1:0] out_found_node,
  output logic [DIST_W-1:0] out_found_dist2,
  output logic [K_W-1:0]    out_found_count,
  output logic [DIST_W-1:0] out_final_radius2,
  output logic              out_last
);

  localparam int HW = $clog2(MAX_K + 1);
  localparam int CW = HW + 1;
  localparam int AW = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int EW = DIST_W + NODE_W;

  typedef enum logic [3:0] {
    H_IDLE, H_BLD_RD, H_BLD_LD, H_TEST, H_CH_A, H_CH_B, H_CMP,
    H_ROOT_RD, H_ROOT_LD, H_DUMP, H_FIN
  } hstate_t;

  hstate_t           state_r;
  logic [HW-1:0]     held_r, k_r, bi_r, o_r;
  logic              ready_r, bld_r, ge_r;
  logic [DIST_W-1:0] bound_r, sd_r, pd_r, cd_r;
  logic [NODE_W-1:0] sn_r, pn_r, cn_r;
  logic [CW-1:0]     par_r, j_r;
  logic              strobe_r, valid_r, last_r;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [EW-1:0]     wdata, rdata;
  logic [DIST_W-1:0] r_dist;
  logic [NODE_W-1:0] r_node;
  logic [CW-1:0]     c1, c2, held_c;
  logic              has_kid, has_kid2, brk, step_done;
  logic [HW-1:0]     half;

  assign r_dist   = rdata[EW-1:NODE_W];
  assign r_node   = rdata[NODE_W-1:0];
  assign held_c   = CW'(held_r);
  assign c1       = {par_r[CW-2:0], 1'b0};
  assign c2       = c1 + 1'b1;
  assign has_kid  = c1 <= held_c;
  assign has_kid2 = c2 <= held_c;
  assign brk      = ge_r ? (sd_r >= cd_r) : (sd_r > cd_r);
  assign half     = held_r >> 1;
  assign step_done = (state_r == H_TEST && !has_kid) || (state_r == H_CMP && brk);

  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = '0;
    raddr = '0;
    wdata = {sd_r, sn_r};
    unique case (state_r)
      H_IDLE: begin
        if (!cmd.clear && cmd.take && held_r < k_r) begin
          we    = 1'b1;
          waddr = AW'(held_r);
          wdata = {cmd.sq_dist, cmd.node};
        end
      end
      H_BLD_RD: begin
        re    = 1'b1;
        raddr = AW'(bi_r - 1'b1);
      end
      H_TEST: begin
        if (has_kid) begin
          re    = 1'b1;
          raddr = AW'(c1 - 1'b1);
        end else begin
          we    = 1'b1;
          waddr = AW'(par_r - 1'b1);
        end
      end
      H_CH_A: begin
        if (has_kid2) begin
          re    = 1'b1;
          raddr = AW'(c1);
        end
      end
      H_CMP: begin
        we    = 1'b1;
        waddr = AW'(par_r - 1'b1);
        wdata = brk ? {sd_r, sn_r} : {cd_r, cn_r};
      end
      H_ROOT_RD: begin
        re = 1'b1;
      end
      H_DUMP: begin
        if (held_r != '0) begin
          re    = 1'b1;
          raddr = AW'(o_r);
        end
      end
      default: begin
      end
    endcase
  end

  kdk_ram #(.WIDTH(EW), .DEPTH(MAX_K)) u_heap_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= H_IDLE;
      held_r   <= '0;
      k_r      <= '0;
      ready_r  <= 1'b0;
      bld_r    <= 1'b0;
      bound_r  <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= 1'b0;
      unique case (state_r)
        H_IDLE: begin
          if (cmd.clear) begin
            held_r  <= '0;
            ready_r <= 1'b0;
            bound_r <= cmd.max_dist2;
            k_r     <= (32'(cmd.k) > MAX_K) ? HW'(MAX_K) : HW'(cmd.k);
          end else if (cmd.take) begin
            if (held_r < k_r) begin
              held_r <= held_r + 1'b1;
            end else if (k_r != '0) begin
              pd_r <= cmd.sq_dist;
              pn_r <= cmd.node;
              if (!ready_r && half != '0) begin
                bi_r    <= half;
                bld_r   <= 1'b1;
                state_r <= H_BLD_RD;
              end else begin
                ready_r <= 1'b1;
                bld_r   <= 1'b0;
                par_r   <= CW'(1);
                sd_r    <= cmd.sq_dist;
                sn_r    <= cmd.node;
                ge_r    <= 1'b0;
                state_r <= H_TEST;
              end
            end
          end else if (cmd.dump) begin
            o_r     <= '0;
            state_r <= H_DUMP;
          end
        end
        H_BLD_RD: state_r <= H_BLD_LD;
        H_BLD_LD: begin
          sd_r    <= r_dist;
          sn_r    <= r_node;
          par_r   <= CW'(bi_r);
          ge_r    <= 1'b1;
          state_r <= H_TEST;
        end
        H_TEST: begin
          if (has_kid) begin
            state_r <= H_CH_A;
          end
        end
        H_CH_A: begin
          cd_r    <= r_dist;
          cn_r    <= r_node;
          j_r     <= c1;
          state_r <= has_kid2 ? H_CH_B : H_CMP;
        end
        H_CH_B: begin
          if (cd_r < r_dist) begin
            cd_r <= r_dist;
            cn_r <= r_node;
            j_r  <= c2;
          end
          state_r <= H_CMP;
        end
        H_CMP: begin
          if (!brk) begin
            par_r   <= j_r;
            state_r <= H_TEST;
          end
        end
        H_ROOT_RD: state_r <= H_ROOT_LD;
        H_ROOT_LD: begin
          bound_r <= r_dist;
          state_r <= H_IDLE;
        end
        H_DUMP: begin
          strobe_r <= 1'b1;
          if (held_r == '0) begin
            valid_r <= 1'b0;
            last_r  <= 1'b1;
            state_r <= H_FIN;
          end else begin
            valid_r <= 1'b1;
            last_r  <= (o_r + 1'b1) == held_r;
            o_r     <= o_r + 1'b1;
            if ((o_r + 1'b1) == held_r) begin
              state_r <= H_FIN;
            end
          end
        end
        H_FIN: state_r <= H_IDLE;
        default: state_r <= H_IDLE;
      endcase
      if (step_done) begin
        if (bld_r) begin
          if (bi_r == HW'(1)) begin
            ready_r <= 1'b1;
            bld_r   <= 1'b0;
            par_r   <= CW'(1);
            sd_r    <= pd_r;
            sn_r    <= pn_r;
            ge_r    <= 1'b0;
            state_r <= H_TEST;
          end else begin
            bi_r    <= bi_r - 1'b1;
            state_r <= H_BLD_RD;
          end
        end else begin
          state_r <= H_ROOT_RD;
        end
      end
    end
  end

  assign sts.busy          = state_r != H_IDLE;
  assign sts.bound         = bound_r;
  assign out_strobe        = strobe_r;
  assign out_entry_valid   = valid_r;
  assign out_found_node    = valid_r ? r_node : '0;
  assign out_found_dist2   = valid_r ? r_dist : '0;
  assign out_found_count   = K_W'(held_r);
  assign out_final_radius2 = bound_r;
  assign out_last          = last_r;

endmodule

// File: rtl/core/kd_tree_k_nearest_search.sv
// Top level of the kd-tree k-nearest-neighbor search: tree store, walk sequencer, register port.
//
// A request is taken when start is high and busy is low. A load request (command 0) writes
// one tree node into slot node_index in that cycle and leaves busy low. A query request
// (command 1) raises busy while the tree is walked depth first, near child first, from
// an explicit stack. Each entry into a node reads the tree memory; one shared 25x25 squarer
// then serves both the split-plane tests and the point distance, and a kept node waits while
// the heap is busy. A leaf is read and its distance taken; an inner node is tested on entry
// and again after its near side, and is read a third time only when its far side is searched.
// Each kept node past the k-th runs a sift through the heap memory and then reads back
// the new bound from the root; the first such node also builds the heap. The query ends
// with one result per node held in the heap, at most k, on consecutive cycles (or one
// result with out_entry_valid low when the heap holds none), each shown for one cycle
// with out_strobe high and out_last on the final one. The receiver cannot stall the
// results.
// Register node_count sits at byte address 0 of the APB-style port and may be written
// only while busy is low. Reset clears node_count and all control state; tree slots
// hold no value until loaded and need no clearing.
module kd_tree_k_nearest_search import kdk_pkg::*; #(
  parameter int TREE_NODES  = TREE_NODES_DEF,
  parameter int MAX_K       = MAX_K_DEF,
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic                         in_command,
  input  logic [NODE_W-1:0]            in_node_index,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  input  logic [AXIS_W-1:0]            in_split_axis,
  input  logic [DIST_W-1:0]            in_max_dist2,
  input  logic [K_W-1:0]               in_k_wanted,
  output logic                         out_strobe,
  output logic                         out_entry_valid,
  output logic [NODE_W-1:0]            out_found_node,
  output logic [DIST_W-1:0]            out_found_dist2,
  output logic [K_W-1:0]               out_found_count,
  output logic [DIST_W-1:0]            out_final_radius2,
  output logic                         out_last,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [DATA_W-1:0]            pwdata,
  output logic [DATA_W-1:0]            prdata,
  output logic                         pready
);

  localparam int LW  = $clog2(TREE_NODES + 1);
  localparam int IW  = LW + 1;
  localparam int TAW = (TREE_NODES > 1) ? $clog2(TREE_NODES) : 1;
  localparam int TEW = 3 * COORD_BITS + AXIS_W;
  localparam int DW  = COORD_BITS + 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);
  localparam int SXW = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_VISIT, S_NODE, S_P1, S_P2, S_D0, S_D1, S_D2, S_D3, S_D4,
    S_TAKE, S_WAIT, S_POP, S_DUMP
  } wstate_t;

  typedef enum logic [1:0] {C_ENTER, C_NEAR, C_FAR} ctx_t;

  localparam logic PH_NEAR = 1'b0;
  localparam logic PH_FAR  = 1'b1;

  wstate_t                   state_r;
  ctx_t                      ctx_r;
  logic [NODE_W-1:0]         node_count_r;
  logic [LW-1:0]             lim_r;
  logic [IW-1:0]             idx_r;
  logic [SPW-1:0]            sp_r;
  logic [LW-1:0]             stk_idx_r [STACK_DEPTH];
  logic                      stk_ph_r  [STACK_DEPTH];
  logic signed [COORD_BITS-1:0] qx_r, qy_r, qz_r;
  logic [DW-1:0]             ad_r;
  logic [2*DW-1:0]           sq_r;
  logic [DIST_W-1:0]         acc_r;
  logic                      neg_r;

  logic                      t_we, t_re;
  logic [TAW-1:0]            t_waddr, t_raddr;
  logic [TEW-1:0]            t_wdata, t_rdata;
  logic signed [COORD_BITS-1:0] nx, ny, nz, qa, na;
  logic [AXIS_W-1:0]         nax;
  logic [IW-1:0]             kid0, kid1;
  logic                      has_kids, out_of_tree, load_ok, accept;
  logic [SXW-1:0]            top;
  heap_cmd_t                 hcmd;
  heap_sts_t                 hsts;

  assign accept   = start && !busy;
  assign load_ok  = in_node_index != '0 && 32'(in_node_index) <= TREE_NODES;
  assign nx       = t_rdata[COORD_BITS-1:0];
  assign ny       = t_rdata[2*COORD_BITS-1:COORD_BITS];
  assign nz       = t_rdata[3*COORD_BITS-1:2*COORD_BITS];
  assign nax      = t_rdata[TEW-1:3*COORD_BITS];
  assign kid0     = {idx_r[IW-2:0], 1'b0};
  assign kid1     = kid0 + 1'b1;
  assign has_kids = kid0 <= IW'(lim_r);
  assign out_of_tree = idx_r == '0 || idx_r > IW'(lim_r);
  assign top      = SXW'(sp_r - 1'b1);

  always_comb begin
    unique case (nax)
      AXIS_X: begin
        qa = qx_r;
        na = nx;
      end
      AXIS_Y: begin
        qa = qy_r;
        na = ny;
      end
      default: begin
        qa = qz_r;
        na = nz;
      end
    endcase
  end

  always_comb begin
    t_we    = accept && in_command == CMD_LOAD && load_ok;
    t_waddr = TAW'(in_node_index - 1'b1);
    t_wdata = {in_split_axis, in_pos_z, in_pos_y, in_pos_x};
    t_re    = 1'b0;
    t_raddr = TAW'(idx_r - 1'b1);
    if (state_r == S_VISIT && !out_of_tree) begin
      t_re = 1'b1;
    end else if (state_r == S_POP && sp_r != '0) begin
      t_re    = 1'b1;
      t_raddr = TAW'(stk_idx_r[top] - 1'b1);
    end
  end

  kdk_ram #(.WIDTH(TEW), .DEPTH(TREE_NODES)) u_tree_ram (
    .clk   (clk),
    .we    (t_we),
    .waddr (t_waddr),
    .wdata (t_wdata),
    .re    (t_re),
    .raddr (t_raddr),
    .rdata (t_rdata)
  );

  always_comb begin
    hcmd.clear     = accept && in_command == CMD_QUERY;
    hcmd.take      = state_r == S_TAKE && acc_r <= hsts.bound;
    hcmd.dump      = state_r == S_POP && sp_r == '0;
    hcmd.sq_dist   = acc_r;
    hcmd.node      = NODE_W'(idx_r);
    hcmd.max_dist2 = in_max_dist2;
    hcmd.k         = in_k_wanted;
  end

  kdk_heap #(.MAX_K(MAX_K)) u_heap (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (hcmd),
    .sts               (hsts),
    .out_strobe        (out_strobe),
    .out_entry_valid   (out_entry_valid),
    .out_found_node    (out_found_node),
    .out_found_dist2   (out_found_dist2),
    .out_found_count   (out_found_count),
    .out_final_radius2 (out_final_radius2),
    .out_last          (out_last)
  );

  always_ff @(posedge clk) begin
    sq_r <= ad_r * ad_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      node_count_r <= '0;
      sp_r         <= '0;
      ctx_r        <= C_ENTER;
    end else begin
      if (psel && penable && pwrite && paddr[2] == REG_NODE_COUNT) begin
        node_count_r <= pwdata[NODE_W-1:0];
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept && in_command == CMD_QUERY) begin
            qx_r    <= in_pos_x;
            qy_r    <= in_pos_y;
            qz_r    <= in_pos_z;
            lim_r   <= (32'(node_count_r) > TREE_NODES) ? LW'(TREE_NODES) : LW'(node_count_r);
            idx_r   <= IW'(1);
            ctx_r   <= C_ENTER;
            sp_r    <= '0;
            state_r <= S_VISIT;
          end
        end
        S_VISIT: state_r <= out_of_tree ? S_POP : S_NODE;
        S_NODE: begin
          if (ctx_r == C_FAR || (ctx_r == C_ENTER && !has_kids)) begin
            state_r <= S_D0;
          end else begin
            ad_r    <= abs_diff(qa, na);
            neg_r   <= qa < na;
            state_r <= S_P1;
          end
        end
        S_P1: state_r <= S_P2;
        S_P2: begin
          if (ctx_r == C_ENTER) begin
            stk_idx_r[SXW'(sp_r)] <= LW'(idx_r);
            stk_ph_r[SXW'(sp_r)]  <= PH_NEAR;
            sp_r    <= sp_r + 1'b1;
            idx_r   <= neg_r ? kid0 : kid1;
            state_r <= S_VISIT;
          end else if (DIST_W'(sq_r) < hsts.bound) begin
            stk_idx_r[SXW'(sp_r)] <= LW'(idx_r);
            stk_ph_r[SXW'(sp_r)]  <= PH_FAR;
            sp_r    <= sp_r + 1'b1;
            idx_r   <= neg_r ? kid1 : kid0;
            ctx_r   <= C_ENTER;
            state_r <= S_VISIT;
          end else begin
            state_r <= S_D0;
          end
        end
        S_D0: begin
          ad_r    <= abs_diff(qx_r, nx);
          state_r <= S_D1;
        end
        S_D1: begin
          ad_r    <= abs_diff(qy_r, ny);
          state_r <= S_D2;
        end
        S_D2: begin
          ad_r    <= abs_diff(qz_r, nz);
          acc_r   <= DIST_W'(sq_r);
          state_r <= S_D3;
        end
        S_D3: begin
          acc_r   <= acc_r + DIST_W'(sq_r);
          state_r <= S_D4;
        end
        S_D4: begin
          acc_r   <= acc_r + DIST_W'(sq_r);
          state_r <= S_TAKE;
        end
        S_TAKE: state_r <= hcmd.take ? S_WAIT : S_POP;
        S_WAIT: begin
          if (!hsts.busy) begin
            state_r <= S_POP;
          end
        end
        S_POP: begin
          if (sp_r == '0) begin
            state_r <= S_DUMP;
          end else begin
            idx_r   <= IW'(stk_idx_r[top]);
            ctx_r   <= (stk_ph_r[top] == PH_FAR) ? C_FAR : C_NEAR;
            sp_r    <= sp_r - 1'b1;
            state_r <= S_NODE;
          end
        end
        S_DUMP: begin
          if (!hsts.busy) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy   = state_r != S_IDLE;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_NODE_COUNT) ? DATA_W'(node_count_r) : '0;

`ifndef ASSERT_OFF
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> busy)
    else $error("result strobe outside a query");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_last |=> !out_strobe)
    else $error("result after the last one of a query");

  a_empty_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_entry_valid |-> out_last && out_found_count == '0)
    else $error("empty result is not a lone final result");

  a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(sp_r) <= STACK_DEPTH)
    else $error("walk stack overflow");
`endif

endmodule
